// ===== src/multigraph_degree_table_defines.svh =====
// Assertion macros shared by the multigraph degree table modules.
`ifndef MULTIGRAPH_DEGREE_TABLE_DEFINES_SVH
`define MULTIGRAPH_DEGREE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MDT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdt check failed");
`define MDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdt check failed");
`else
`define MDT_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MDT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/mdt_pkg.sv =====
// Types and request codes shared by the multigraph degree table modules.
package mdt_pkg;
   localparam logic [2:0] REQ_ADD_VERTEX    = 3'd0;
   localparam logic [2:0] REQ_ADD_AUTO      = 3'd1;
   localparam logic [2:0] REQ_REMOVE_VERTEX = 3'd2;
   localparam logic [2:0] REQ_ADD_EDGE      = 3'd3;
   localparam logic [2:0] REQ_REMOVE_COUNT  = 3'd4;
   localparam logic [2:0] REQ_REMOVE_ALL    = 3'd5;
   localparam logic [2:0] REQ_QUERY         = 3'd6;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  vertex_a;
      logic [7:0]  vertex_b;
      logic [15:0] copies;
   } mdt_req_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] multiplicity;
      logic [31:0] degree_a;
      logic [31:0] degree_b;
      logic [8:0]  neighbours_a;
      logic [8:0]  neighbours_b;
      logic [8:0]  vertex_total;
      logic [31:0] edge_total;
      logic [15:0] distinct_total;
      logic [7:0]  new_vertex;
   } mdt_rsp_type;

   typedef struct packed {
      logic [31:0] degree;
      logic [8:0]  neighbours;
   } mdt_vtx_type;

   typedef struct packed {
      logic latch;
      logic clear;
      logic read_a;
      logic read_b;
      logic execute;
      logic write_a;
      logic write_b;
      logic walk_read;
      logic walk_check;
      logic walk_update;
      logic final_a;
      logic final_b;
      logic final_c;
   } mdt_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_needed;
      logic walk_hit;
      logic walk_last;
   } mdt_status_type;
endpackage

// ===== src/multigraph_degree_table.sv =====
// Top level of the multigraph degree table: sequencer plus datapath.
//
// A request transaction is accepted at a rising edge with start high and busy low;
// req_payload carries the request code, the two vertex ids and the copy count.
// busy stays high until the request is finished. Exactly one result follows each
// request: rsp_payload is valid for the single cycle in which rsp_valid is high,
// and the receiver cannot stall it.
// An edge, vertex-add or query request steps through the read, execute, write and
// readback states before the result strobe; the next request may start in the strobe
// cycle. The single-port pair table and vertex record memory are read, updated and
// read back in turn. A successful vertex removal also walks the vertex's table row,
// reading each row entry and clearing each edge found there.
// After reset the pair table is swept to zero, one entry per cycle, with busy high;
// presence bits, totals and control registers are cleared by reset, and a vertex
// record is zeroed when its vertex is added or removed.
`include "multigraph_degree_table_defines.svh"
module multigraph_degree_table #(
   parameter int NODES     = 256,
   parameter int COPY_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mdt_pkg::mdt_req_type req_payload,
   output logic                rsp_valid,
   output mdt_pkg::mdt_rsp_type rsp_payload
);
   import mdt_pkg::*;

   mdt_cmd_type    cmd;
   mdt_status_type status;

   mdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status_in (status),
      .cmd_out   (cmd)
   );

   mdt_dp #(
      .NODES     (NODES),
      .COPY_BITS (COPY_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd_in      (cmd),
      .status_out  (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   `MDT_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `MDT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

// ===== src/mdt_ctrl.sv =====
// Sequencer that steps each transaction through read, update, walk (vertex removal only) and readback phases.
`include "multigraph_degree_table_defines.svh"
module mdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mdt_pkg::mdt_status_type status_in,
   output mdt_pkg::mdt_cmd_type    cmd_out
);
   import mdt_pkg::*;

   typedef enum logic [12:0] {
      ST_CLEAR       = 13'b0000000000001,
      ST_IDLE        = 13'b0000000000010,
      ST_READ_A      = 13'b0000000000100,
      ST_READ_B      = 13'b0000000001000,
      ST_EXECUTE     = 13'b0000000010000,
      ST_WRITE_A     = 13'b0000000100000,
      ST_WRITE_B     = 13'b0000001000000,
      ST_WALK_READ   = 13'b0000010000000,
      ST_WALK_CHECK  = 13'b0000100000000,
      ST_WALK_UPDATE = 13'b0001000000000,
      ST_FINAL_A     = 13'b0010000000000,
      ST_FINAL_B     = 13'b0100000000000,
      ST_FINAL_C     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status_in.clear_done) state_in = ST_IDLE;
         ST_IDLE: if (start) state_in = ST_READ_A;
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: state_in = ST_EXECUTE;
         ST_EXECUTE: state_in = ST_WRITE_A;
         ST_WRITE_A: state_in = ST_WRITE_B;
         ST_WRITE_B: state_in = status_in.walk_needed ? ST_WALK_READ : ST_FINAL_A;
         ST_WALK_READ: state_in = ST_WALK_CHECK;
         ST_WALK_CHECK: begin
            if (status_in.walk_hit) state_in = ST_WALK_UPDATE;
            else if (status_in.walk_last) state_in = ST_FINAL_A;
            else state_in = ST_WALK_READ;
         end
         ST_WALK_UPDATE: state_in = status_in.walk_last ? ST_FINAL_A : ST_WALK_READ;
         ST_FINAL_A: state_in = ST_FINAL_B;
         ST_FINAL_B: state_in = ST_FINAL_C;
         ST_FINAL_C: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd_out.latch       = (state_ff == ST_IDLE) && start;
      cmd_out.clear       = (state_ff == ST_CLEAR);
      cmd_out.read_a      = (state_ff == ST_READ_A);
      cmd_out.read_b      = (state_ff == ST_READ_B);
      cmd_out.execute     = (state_ff == ST_EXECUTE);
      cmd_out.write_a     = (state_ff == ST_WRITE_A);
      cmd_out.write_b     = (state_ff == ST_WRITE_B);
      cmd_out.walk_read   = (state_ff == ST_WALK_READ);
      cmd_out.walk_check  = (state_ff == ST_WALK_CHECK);
      cmd_out.walk_update = (state_ff == ST_WALK_UPDATE);
      cmd_out.final_a     = (state_ff == ST_FINAL_A);
      cmd_out.final_b     = (state_ff == ST_FINAL_B);
      cmd_out.final_c     = (state_ff == ST_FINAL_C);
   end

   `MDT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MDT_ASSERT_SAME(a_update_on_hit, clock, reset, state_ff == ST_WALK_UPDATE,
      $past(status_in.walk_hit))
endmodule

// ===== src/mdt_dp.sv =====
// Datapath: presence bits, pair table, vertex records, totals and response register.
`include "multigraph_degree_table_defines.svh"
module mdt_dp #(
   parameter int NODES     = 256,
   parameter int COPY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mdt_pkg::mdt_req_type    req_payload,
   input  mdt_pkg::mdt_cmd_type    cmd_in,
   output mdt_pkg::mdt_status_type status_out,
   output logic                   rsp_valid,
   output mdt_pkg::mdt_rsp_type    rsp_payload
);
   import mdt_pkg::*;

   localparam int VN = (NODES < 256) ? NODES : 256;
   localparam int VB = $clog2(VN);
   localparam int PB = 2 * VB;
   localparam int PD = 1 << PB;
   localparam logic [8:0] VN_C = 9'(VN);
   localparam logic [VB-1:0] LAST_J = VB'(VN - 1);
   localparam logic [32:0] COPY_MAX = 33'((64'd1 << COPY_BITS) - 64'd1);

   function automatic logic in_range(input logic [7:0] x);
      return {1'b0, x} < VN_C;
   endfunction

   function automatic logic [PB-1:0] pair_addr(input logic [VB-1:0] x,
                                                input logic [VB-1:0] y);
      return (x < y) ? {y, x} : {x, y};
   endfunction

   mdt_req_type       req_ff;
   logic [7:0]        tgt_ff;
   logic [VN-1:0]     present_ff;
   logic [COPY_BITS-1:0] pair_mem [PD];
   logic [COPY_BITS-1:0] pair_rd_ff;
   mdt_vtx_type       vtx_mem [VN];
   mdt_vtx_type       vtx_rd_ff;
   logic [COPY_BITS-1:0] e_ff, pair_new_ff, fin_pair_ff;
   mdt_vtx_type       va_ff, va_new_ff, vb_new_ff, fin_a_ff;
   logic              ok_ff, edge_wr_ff, vtx_zero_ff, walk_ff;
   logic [VB-1:0]     walk_j_ff;
   logic [PB:0]       clr_cnt_ff;
   logic [8:0]        vertices_ff;
   logic [31:0]       edges_ff;
   logic [15:0]       distinct_ff;
   logic [7:0]        next_id_ff;
   logic              rsp_valid_ff;
   mdt_rsp_type       rsp_ff;

   logic [VB-1:0]     ia, ib, it;
   logic              pa, pb, self;
   logic [PB-1:0]     pair_raddr, pair_waddr;
   logic              pair_re, pair_we;
   logic [COPY_BITS-1:0] pair_wdata;
   logic [VB-1:0]     vtx_raddr, vtx_waddr;
   logic              vtx_re, vtx_we;
   mdt_vtx_type       vtx_wdata;
   logic [31:0]       e32, n32, amt32, dmul, walk_e32;
   logic [32:0]       sum33;
   logic [8:0]        nstep;
   logic              ok_c, grow, shrink, drop, vadd, vrem;
   logic [COPY_BITS-1:0] pair_new_c;
   mdt_vtx_type       va_new_c, vb_new_c;

   assign ia   = req_ff.vertex_a[VB-1:0];
   assign ib   = req_ff.vertex_b[VB-1:0];
   assign it   = tgt_ff[VB-1:0];
   assign pa   = in_range(req_ff.vertex_a) && present_ff[ia];
   assign pb   = in_range(req_ff.vertex_b) && present_ff[ib];
   assign self = (req_ff.vertex_a == req_ff.vertex_b);
   assign walk_e32 = 32'(pair_rd_ff);

   // Request decision, evaluated in the execute step with both vertex records at hand.
   always_comb begin
      e32    = 32'(e_ff);
      n32    = 32'(req_ff.copies);
      sum33  = {1'b0, e32} + {17'd0, req_ff.copies};
      ok_c   = 1'b0;
      grow   = 1'b0;
      shrink = 1'b0;
      drop   = 1'b0;
      vadd   = 1'b0;
      vrem   = 1'b0;
      amt32  = n32;
      case (req_ff.req_type)
         REQ_ADD_VERTEX, REQ_ADD_AUTO: begin
            ok_c = in_range(tgt_ff) && !present_ff[it];
            vadd = 1'b1;
         end
         REQ_REMOVE_VERTEX: begin
            ok_c = pa;
            vrem = 1'b1;
         end
         REQ_ADD_EDGE: begin
            ok_c = pa && pb && (n32 != 32'd0) && (sum33 <= COPY_MAX);
            grow = 1'b1;
         end
         REQ_REMOVE_COUNT: begin
            ok_c   = pa && pb && (e32 != 32'd0) && (n32 != 32'd0) && (n32 <= e32);
            shrink = 1'b1;
            drop   = (n32 == e32);
         end
         REQ_REMOVE_ALL: begin
            ok_c   = pa && pb && (e32 != 32'd0);
            shrink = 1'b1;
            drop   = 1'b1;
            amt32  = e32;
         end
         REQ_QUERY: ok_c = pa && pb;
         default: ok_c = 1'b0;
      endcase
      // A self-loop counts twice on its one vertex.
      dmul  = self ? (amt32 << 1) : amt32;
      nstep = self ? 9'd2 : 9'd1;
      va_new_c = va_ff;
      vb_new_c = vtx_rd_ff;
      pair_new_c = e_ff;
      if (grow) begin
         pair_new_c = sum33[COPY_BITS-1:0];
         va_new_c.degree = va_ff.degree + dmul;
         vb_new_c.degree = vtx_rd_ff.degree + dmul;
         if (e32 == 32'd0) begin
            va_new_c.neighbours = va_ff.neighbours + nstep;
            vb_new_c.neighbours = vtx_rd_ff.neighbours + nstep;
         end
      end else if (shrink) begin
         pair_new_c = drop ? '0 : COPY_BITS'(e32 - amt32);
         va_new_c.degree = va_ff.degree - dmul;
         vb_new_c.degree = vtx_rd_ff.degree - dmul;
         if (drop) begin
            va_new_c.neighbours = va_ff.neighbours - nstep;
            vb_new_c.neighbours = vtx_rd_ff.neighbours - nstep;
         end
      end
   end

   // Pair table ports.
   always_comb begin
      pair_re    = cmd_in.read_a || cmd_in.walk_read || cmd_in.final_a;
      pair_raddr = cmd_in.walk_read ? pair_addr(it, walk_j_ff) : pair_addr(ia, ib);
      pair_we    = 1'b0;
      pair_waddr = pair_addr(ia, ib);
      pair_wdata = pair_new_ff;
      if (cmd_in.clear) begin
         pair_we    = !clr_cnt_ff[PB];
         pair_waddr = clr_cnt_ff[PB-1:0];
         pair_wdata = '0;
      end else if (cmd_in.write_a) begin
         pair_we = edge_wr_ff;
      end else if (cmd_in.walk_update) begin
         pair_we    = 1'b1;
         pair_waddr = pair_addr(it, walk_j_ff);
         pair_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
   end

   always_ff @(posedge clock) begin
      if (pair_re) pair_rd_ff <= pair_mem[pair_raddr];
   end

   // Vertex record ports.
   always_comb begin
      vtx_re    = cmd_in.read_a || cmd_in.read_b || cmd_in.walk_check ||
                  cmd_in.final_a || cmd_in.final_b;
      vtx_raddr = ia;
      if (cmd_in.read_b || cmd_in.final_b) vtx_raddr = ib;
      else if (cmd_in.walk_check) vtx_raddr = walk_j_ff;
      vtx_we    = 1'b0;
      vtx_waddr = ia;
      vtx_wdata = va_new_ff;
      if (cmd_in.write_a) begin
         if (vtx_zero_ff) begin
            vtx_we    = 1'b1;
            vtx_waddr = it;
            vtx_wdata = '0;
         end else begin
            vtx_we = edge_wr_ff;
         end
      end else if (cmd_in.write_b) begin
         vtx_we    = edge_wr_ff;
         vtx_waddr = ib;
         vtx_wdata = vb_new_ff;
      end else if (cmd_in.walk_update) begin
         // The removed vertex itself is zeroed already.
         vtx_we    = (walk_j_ff != it);
         vtx_waddr = walk_j_ff;
         vtx_wdata.degree     = vtx_rd_ff.degree - walk_e32;
         vtx_wdata.neighbours = vtx_rd_ff.neighbours - 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (vtx_we) vtx_mem[vtx_waddr] <= vtx_wdata;
   end

   always_ff @(posedge clock) begin
      if (vtx_re) vtx_rd_ff <= vtx_mem[vtx_raddr];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd_in.latch) begin
         req_ff <= req_payload;
         tgt_ff <= (req_payload.req_type == REQ_ADD_AUTO) ? next_id_ff
                                                           : req_payload.vertex_a;
         walk_j_ff <= '0;
      end else if ((cmd_in.walk_check && !status_out.walk_hit) || cmd_in.walk_update) begin
         walk_j_ff <= walk_j_ff + VB'(1);
      end
      if (cmd_in.read_b) begin
         e_ff  <= pair_rd_ff;
         va_ff <= vtx_rd_ff;
      end
      if (cmd_in.execute) begin
         ok_ff       <= ok_c;
         pair_new_ff <= pair_new_c;
         va_new_ff   <= va_new_c;
         vb_new_ff   <= vb_new_c;
      end
      if (cmd_in.final_b) begin
         fin_pair_ff <= pair_rd_ff;
         fin_a_ff    <= vtx_rd_ff;
      end
   end

   // Control and total registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         clr_cnt_ff   <= '0;
         vertices_ff  <= '0;
         edges_ff     <= '0;
         distinct_ff  <= '0;
         next_id_ff   <= '0;
         edge_wr_ff   <= 1'b0;
         vtx_zero_ff  <= 1'b0;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_in.final_c;
         if (cmd_in.clear && !clr_cnt_ff[PB]) clr_cnt_ff <= clr_cnt_ff + (PB+1)'(1);
         if (cmd_in.execute) begin
            edge_wr_ff  <= ok_c && (grow || shrink);
            vtx_zero_ff <= ok_c && (vadd || vrem);
            walk_ff     <= ok_c && vrem;
            if (ok_c) begin
               if (vadd) begin
                  present_ff[it] <= 1'b1;
                  vertices_ff    <= vertices_ff + 9'd1;
                  if (req_ff.req_type == REQ_ADD_AUTO) next_id_ff <= next_id_ff + 8'd1;
               end
               if (vrem) begin
                  present_ff[ia] <= 1'b0;
                  vertices_ff    <= vertices_ff - 9'd1;
               end
               if (grow) begin
                  edges_ff <= edges_ff + amt32;
                  if (e32 == 32'd0) distinct_ff <= distinct_ff + 16'd1;
               end
               if (shrink) begin
                  edges_ff <= edges_ff - amt32;
                  if (drop) distinct_ff <= distinct_ff - 16'd1;
               end
            end
         end
         if (cmd_in.walk_update) begin
            edges_ff    <= edges_ff - walk_e32;
            distinct_ff <= distinct_ff - 16'd1;
         end
      end
   end

   // Response assembly from the readback.
   always_ff @(posedge clock) begin
      if (cmd_in.final_c) begin
         rsp_ff.ok             <= ok_ff;
         rsp_ff.multiplicity   <= (pa && pb) ? 16'(32'(fin_pair_ff)) : 16'd0;
         rsp_ff.degree_a       <= pa ? fin_a_ff.degree : 32'd0;
         rsp_ff.neighbours_a   <= pa ? fin_a_ff.neighbours : 9'd0;
         rsp_ff.degree_b       <= pb ? vtx_rd_ff.degree : 32'd0;
         rsp_ff.neighbours_b   <= pb ? vtx_rd_ff.neighbours : 9'd0;
         rsp_ff.vertex_total   <= vertices_ff;
         rsp_ff.edge_total     <= edges_ff;
         rsp_ff.distinct_total <= distinct_ff;
         rsp_ff.new_vertex     <= (req_ff.req_type == REQ_ADD_AUTO) ? tgt_ff : 8'd0;
      end
   end

   always_comb begin
      status_out.clear_done  = clr_cnt_ff[PB];
      status_out.walk_needed = walk_ff;
      status_out.walk_hit    = (pair_rd_ff != '0);
      status_out.walk_last   = (walk_j_ff == LAST_J);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MDT_ASSERT_SAME(a_vertex_bound, clock, reset, 1'b1, vertices_ff <= VN_C)
endmodule
